// File: rtl/core/cisc_pkg.sv
// ----------------------------------------------------------------------------
// cisc_pkg
// Shared types, opcodes and constants of the 8-bit bus-driven CPU core.
// ----------------------------------------------------------------------------
package cisc_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_FETCH = 3'd1,
    PH_IMM1  = 3'd2,
    PH_IMM2  = 3'd3,
    PH_DATA  = 3'd4
  } phase_t;

  localparam logic [7:0] OP_LD_BC_NN = 8'h01;
  localparam logic [7:0] OP_DEC_B    = 8'h05;
  localparam logic [7:0] OP_LD_B_N   = 8'h06;
  localparam logic [7:0] OP_LD_NN_SP = 8'h08;
  localparam logic [7:0] OP_INC_C    = 8'h0C;
  localparam logic [7:0] OP_DEC_C    = 8'h0D;
  localparam logic [7:0] OP_LD_C_N   = 8'h0E;
  localparam logic [7:0] OP_LD_DE_NN = 8'h11;
  localparam logic [7:0] OP_DEC_D    = 8'h15;
  localparam logic [7:0] OP_LD_D_N   = 8'h16;
  localparam logic [7:0] OP_LD_A_DE  = 8'h1A;
  localparam logic [7:0] OP_LD_E_N   = 8'h1E;
  localparam logic [7:0] OP_JR_NZ    = 8'h20;
  localparam logic [7:0] OP_LD_HL_NN = 8'h21;
  localparam logic [7:0] OP_INC_HL   = 8'h23;
  localparam logic [7:0] OP_LD_SP_NN = 8'h31;
  localparam logic [7:0] OP_LDD_HL_A = 8'h32;
  localparam logic [7:0] OP_LD_A_N   = 8'h3E;
  localparam logic [7:0] OP_LD_HL_A  = 8'h77;
  localparam logic [7:0] OP_ADD_B    = 8'h80;
  localparam logic [7:0] OP_ADD_C    = 8'h81;
  localparam logic [7:0] OP_ADD_A    = 8'h87;
  localparam logic [7:0] OP_SUB_B    = 8'h90;
  localparam logic [7:0] OP_AND_B    = 8'hA0;
  localparam logic [7:0] OP_XOR_B    = 8'hA8;
  localparam logic [7:0] OP_XOR_A    = 8'hAF;
  localparam logic [7:0] OP_OR_B     = 8'hB0;
  localparam logic [7:0] OP_JP_NN    = 8'hC3;

  localparam logic [15:0] START_ADDR_RESET  = 16'h0100;
  localparam logic [15:0] START_STACK_RESET = 16'hFFFE;

  localparam logic [0:0] REG_START_ADDR  = 1'b0;
  localparam logic [0:0] REG_START_STACK = 1'b1;

  typedef struct packed {
    logic [15:0] bus_address;
    logic [7:0]  write_data;
    logic        is_write;
    logic        last;
    logic        instr_done;
    logic [4:0]  cycles_done;
  } beat_t;

  typedef struct packed {
    logic [1:0] count;
    beat_t      b0;
    beat_t      b1;
    beat_t      b2;
  } step_t;

  function automatic beat_t rd_beat(logic [15:0] a, logic done, logic [4:0] cyc);
    beat_t r;
    r.bus_address = a;
    r.write_data  = 8'h00;
    r.is_write    = 1'b0;
    r.last        = 1'b1;
    r.instr_done  = done;
    r.cycles_done = cyc;
    return r;
  endfunction

  function automatic beat_t wr_beat(logic [15:0] a, logic [7:0] d);
    beat_t r;
    r.bus_address = a;
    r.write_data  = d;
    r.is_write    = 1'b1;
    r.last        = 1'b0;
    r.instr_done  = 1'b0;
    r.cycles_done = 5'd0;
    return r;
  endfunction

endpackage

// File: rtl/core/cisc_if.sv
// ----------------------------------------------------------------------------
// cisc_in_if / cisc_out_if
// Valid-ready channels for bus responses and bus requests.
// ----------------------------------------------------------------------------
interface cisc_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] read_data;
  modport source (output valid, kind, read_data, input ready);
  modport sink (input valid, kind, read_data, output ready);
endinterface

interface cisc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] bus_address;
  logic [7:0]  write_data;
  logic        is_write;
  logic        last;
  logic        instr_done;
  logic [4:0]  cycles_done;
  modport source (output valid, bus_address, write_data, is_write, last, instr_done,
                  cycles_done, input ready);
  modport sink (input valid, bus_address, write_data, is_write, last, instr_done,
                cycles_done, output ready);
endinterface

// File: rtl/core/cisc_exec.sv
// ----------------------------------------------------------------------------
// cisc_exec
// Architectural state and single-pass decode/execute of one bus response.
// ----------------------------------------------------------------------------
module cisc_exec (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_sel,
  input  logic [15:0]          cfg_data,
  output logic [15:0]          start_address,
  output logic [15:0]          start_stack,
  input  logic                 step_en,
  input  logic                 kind,
  input  logic [7:0]           read_data,
  output cisc_pkg::step_t      step
);

  cisc_pkg::phase_t phase, phase_next;
  logic [15:0] pc, pc_next, sp, sp_next;
  logic [7:0]  acc, acc_next;
  logic [3:0]  flags, flags_next;
  logic [7:0]  regs [6];
  logic [7:0]  regs_next [6];
  logic [7:0]  opcode, opcode_next, low_byte, low_byte_next;

  logic [15:0] hl, de, imm16, pc1;
  logic [8:0]  sum;
  logic [7:0]  addend, res;
  logic        one_imm, two_imm, latch_two;

  always_comb begin
    hl    = {regs[4], regs[5]};
    de    = {regs[2], regs[3]};
    imm16 = {read_data, low_byte};
    pc1   = pc + 16'd1;
    one_imm = (read_data inside {cisc_pkg::OP_LD_B_N, cisc_pkg::OP_LD_C_N,
      cisc_pkg::OP_LD_D_N, cisc_pkg::OP_LD_E_N, cisc_pkg::OP_LD_A_N, cisc_pkg::OP_JR_NZ});
    two_imm = (read_data inside {cisc_pkg::OP_LD_BC_NN, cisc_pkg::OP_LD_DE_NN,
      cisc_pkg::OP_LD_HL_NN, cisc_pkg::OP_LD_SP_NN, cisc_pkg::OP_LD_NN_SP, cisc_pkg::OP_JP_NN});
    latch_two = (opcode inside {cisc_pkg::OP_LD_BC_NN, cisc_pkg::OP_LD_DE_NN,
      cisc_pkg::OP_LD_HL_NN, cisc_pkg::OP_LD_SP_NN, cisc_pkg::OP_LD_NN_SP, cisc_pkg::OP_JP_NN});
    case (read_data)
      cisc_pkg::OP_ADD_C: addend = regs[1];
      cisc_pkg::OP_ADD_A: addend = acc;
      default:            addend = regs[0];
    endcase
    sum = {1'b0, acc} + {1'b0, addend};
    res = 8'h00;

    phase_next    = phase;
    pc_next       = pc;
    sp_next       = sp;
    acc_next      = acc;
    flags_next    = flags;
    regs_next     = regs;
    opcode_next   = opcode;
    low_byte_next = low_byte;
    step.count    = 2'd0;
    step.b0       = cisc_pkg::rd_beat(pc, 1'b1, 5'd0);
    step.b1       = step.b0;
    step.b2       = step.b0;

    if (!kind) begin
      pc_next    = start_address;
      phase_next = cisc_pkg::PH_FETCH;
      step.count = 2'd1;
      step.b0    = cisc_pkg::rd_beat(start_address, 1'b1, 5'd0);
    end else begin
      case (phase)
        cisc_pkg::PH_FETCH: begin
          pc_next     = pc1;
          opcode_next = read_data;
          step.count  = 2'd1;
          if (one_imm || two_imm) begin
            phase_next = cisc_pkg::PH_IMM1;
            step.b0    = cisc_pkg::rd_beat(pc1, 1'b0, 5'd0);
          end else if (read_data == cisc_pkg::OP_LD_A_DE) begin
            phase_next = cisc_pkg::PH_DATA;
            step.b0    = cisc_pkg::rd_beat(de, 1'b0, 5'd0);
          end else begin
            phase_next = cisc_pkg::PH_FETCH;
            step.b0    = cisc_pkg::rd_beat(pc1, 1'b1, 5'd4);
            case (read_data)
              cisc_pkg::OP_DEC_B, cisc_pkg::OP_DEC_C, cisc_pkg::OP_DEC_D: begin
                case (read_data)
                  cisc_pkg::OP_DEC_B: res = regs[0];
                  cisc_pkg::OP_DEC_C: res = regs[1];
                  default:            res = regs[2];
                endcase
                flags_next = {res == 8'h01, 1'b1, res[3:0] == 4'h0, flags[0]};
                res = res - 8'd1;
                case (read_data)
                  cisc_pkg::OP_DEC_B: regs_next[0] = res;
                  cisc_pkg::OP_DEC_C: regs_next[1] = res;
                  default:            regs_next[2] = res;
                endcase
              end
              cisc_pkg::OP_INC_C: begin
                regs_next[1] = regs[1] + 8'd1;
                flags_next = {regs[1] == 8'hFF, 1'b0, regs[1][3:0] == 4'hF, flags[0]};
              end
              cisc_pkg::OP_INC_HL: begin
                {regs_next[4], regs_next[5]} = hl + 16'd1;
                step.b0.cycles_done = 5'd8;
              end
              cisc_pkg::OP_LDD_HL_A, cisc_pkg::OP_LD_HL_A: begin
                if (read_data == cisc_pkg::OP_LDD_HL_A) begin
                  {regs_next[4], regs_next[5]} = hl - 16'd1;
                end
                step.count = 2'd2;
                step.b1 = cisc_pkg::rd_beat(pc1, 1'b1, 5'd8);
                step.b0 = cisc_pkg::wr_beat(hl, acc);
              end
              cisc_pkg::OP_ADD_B, cisc_pkg::OP_ADD_C, cisc_pkg::OP_ADD_A: begin
                acc_next = sum[7:0];
                flags_next = {sum[7:0] == 8'h00, 1'b0,
                              ({1'b0, acc[3:0]} + {1'b0, addend[3:0]}) > 5'h0F, sum[8]};
              end
              cisc_pkg::OP_SUB_B: begin
                acc_next = acc - regs[0];
                flags_next = {acc == regs[0], 1'b1, acc[3:0] < regs[0][3:0], acc < regs[0]};
              end
              cisc_pkg::OP_AND_B: begin
                acc_next = acc & regs[0];
                flags_next = {(acc & regs[0]) == 8'h00, 3'b010};
              end
              cisc_pkg::OP_XOR_B: begin
                acc_next = acc ^ regs[0];
                flags_next = {(acc ^ regs[0]) == 8'h00, 3'b000};
              end
              cisc_pkg::OP_OR_B: begin
                acc_next = acc | regs[0];
                flags_next = {(acc | regs[0]) == 8'h00, 3'b000};
              end
              cisc_pkg::OP_XOR_A: begin
                acc_next = 8'h00;
                flags_next = 4'b1000;
              end
              default: ;
            endcase
          end
        end
        cisc_pkg::PH_IMM1: begin
          pc_next    = pc1;
          step.count = 2'd1;
          phase_next = cisc_pkg::PH_FETCH;
          step.b0    = cisc_pkg::rd_beat(pc1, 1'b1, 5'd8);
          if (latch_two) begin
            low_byte_next = read_data;
            phase_next    = cisc_pkg::PH_IMM2;
            step.b0       = cisc_pkg::rd_beat(pc1, 1'b0, 5'd0);
          end else begin
            case (opcode)
              cisc_pkg::OP_LD_B_N: regs_next[0] = read_data;
              cisc_pkg::OP_LD_C_N: regs_next[1] = read_data;
              cisc_pkg::OP_LD_D_N: regs_next[2] = read_data;
              cisc_pkg::OP_LD_E_N: regs_next[3] = read_data;
              cisc_pkg::OP_LD_A_N: acc_next = read_data;
              cisc_pkg::OP_JR_NZ: begin
                if (!flags[3]) begin
                  pc_next = pc1 + {{8{read_data[7]}}, read_data};
                  step.b0 = cisc_pkg::rd_beat(pc_next, 1'b1, 5'd12);
                end
              end
              default: step.b0.cycles_done = 5'd4;
            endcase
          end
        end
        cisc_pkg::PH_IMM2: begin
          pc_next    = pc1;
          phase_next = cisc_pkg::PH_FETCH;
          step.count = 2'd1;
          step.b0    = cisc_pkg::rd_beat(pc1, 1'b1, 5'd12);
          case (opcode)
            cisc_pkg::OP_LD_BC_NN: {regs_next[0], regs_next[1]} = imm16;
            cisc_pkg::OP_LD_DE_NN: {regs_next[2], regs_next[3]} = imm16;
            cisc_pkg::OP_LD_HL_NN: {regs_next[4], regs_next[5]} = imm16;
            cisc_pkg::OP_LD_SP_NN: sp_next = imm16;
            cisc_pkg::OP_LD_NN_SP: begin
              step.count = 2'd3;
              step.b0 = cisc_pkg::wr_beat(imm16, sp[7:0]);
              step.b1 = cisc_pkg::wr_beat(imm16 + 16'd1, sp[15:8]);
              step.b2 = cisc_pkg::rd_beat(pc1, 1'b1, 5'd20);
            end
            cisc_pkg::OP_JP_NN: begin
              pc_next = imm16;
              step.b0 = cisc_pkg::rd_beat(imm16, 1'b1, 5'd16);
            end
            default: step.b0.cycles_done = 5'd4;
          endcase
        end
        cisc_pkg::PH_DATA: begin
          acc_next   = read_data;
          phase_next = cisc_pkg::PH_FETCH;
          step.count = 2'd1;
          step.b0    = cisc_pkg::rd_beat(pc, 1'b1, 5'd8);
        end
        default: step.count = 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= cisc_pkg::PH_IDLE;
      start_address <= cisc_pkg::START_ADDR_RESET;
      start_stack   <= cisc_pkg::START_STACK_RESET;
      pc            <= cisc_pkg::START_ADDR_RESET;
      sp            <= cisc_pkg::START_STACK_RESET;
      acc           <= 8'h00;
      flags         <= 4'h0;
      opcode        <= 8'h00;
      low_byte      <= 8'h00;
      for (int i = 0; i < 6; i++) begin
        regs[i] <= 8'h00;
      end
    end else if (cfg_we) begin
      if (cfg_sel == cisc_pkg::REG_START_ADDR) begin
        start_address <= cfg_data;
      end else begin
        start_stack <= cfg_data;
        sp          <= cfg_data;
      end
    end else if (step_en) begin
      phase    <= phase_next;
      pc       <= pc_next;
      sp       <= sp_next;
      acc      <= acc_next;
      flags    <= flags_next;
      opcode   <= opcode_next;
      low_byte <= low_byte_next;
      regs     <= regs_next;
    end
  end

endmodule

// File: rtl/core/cisc_outq.sv
// ----------------------------------------------------------------------------
// cisc_outq
// Result buffer holding up to three bus beats of one step, drained in order.
// ----------------------------------------------------------------------------
module cisc_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  cisc_pkg::step_t    step,
  output logic               can_load,
  cisc_out_if.source         out_ch
);

  cisc_pkg::beat_t slot [3];
  logic [1:0] cnt, head;
  logic       pop;

  assign pop      = out_ch.valid && out_ch.ready;
  assign can_load = (cnt == 2'd0) || (pop && cnt == 2'd1);

  assign out_ch.valid       = cnt != 2'd0;
  assign out_ch.bus_address = slot[head].bus_address;
  assign out_ch.write_data  = slot[head].write_data;
  assign out_ch.is_write    = slot[head].is_write;
  assign out_ch.last        = slot[head].last;
  assign out_ch.instr_done  = slot[head].instr_done;
  assign out_ch.cycles_done = slot[head].cycles_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= 2'd0;
      head <= 2'd0;
    end else if (load) begin
      cnt  <= step.count;
      head <= 2'd0;
    end else if (pop) begin
      cnt  <= cnt - 2'd1;
      head <= head + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot[0] <= step.b0;
      slot[1] <= step.b1;
      slot[2] <= step.b2;
    end
  end

endmodule

// File: rtl/core/cpu_instruction_subset_core.sv
// A bus response beat yields its first request beat in the cycle after it.
// One response per cycle while each step makes one request beat and out_ch
// is ready; write steps put out up to three beats, the last freeing the input.
// Reset (rst, synchronous): PC 0x0100, SP 0xFFFE, other state zero, core idle
// until a start beat arrives.
// ----------------------------------------------------------------------------
// cpu_instruction_subset_core
// Bus-driven 8-bit CPU core with an APB register port for start values.
// ----------------------------------------------------------------------------
module cpu_instruction_subset_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:2]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  cisc_in_if.sink     in_ch,
  cisc_out_if.source  out_ch
);

  cisc_pkg::step_t step;
  logic [15:0] start_address, start_stack;
  logic can_load, take, cfg_we;

  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite;
  assign prdata   = {16'h0000, paddr[2] ? start_stack : start_address};
  assign in_ch.ready = can_load;
  assign take     = in_ch.valid && can_load;

  cisc_exec u_exec (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_sel(paddr[2]),
    .cfg_data(pwdata[15:0]), .start_address(start_address), .start_stack(start_stack),
    .step_en(take), .kind(in_ch.kind), .read_data(in_ch.read_data), .step(step)
  );

  cisc_outq u_outq (
    .clk(clk), .rst(rst), .load(take), .step(step), .can_load(can_load), .out_ch(out_ch)
  );

endmodule

// File: rtl/core/cisc_checker.sv
// ----------------------------------------------------------------------------
// cisc_checker
// Port-level checks of the core's request stream.
// ----------------------------------------------------------------------------
module cisc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        is_write,
  input logic        last,
  input logic        instr_done,
  input logic [4:0]  cycles_done,
  input logic [15:0] bus_address
);

  a_write_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_write |-> !last && !instr_done && cycles_done == 5'd0)
    else $error("write beat marked as request end");

  a_read_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_write |-> last)
    else $error("read request not marked last");

  a_cycles_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && instr_done |-> cycles_done <= 5'd20)
    else $error("cycle count out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bus_address))
    else $error("stalled beat changed");

endmodule

bind cpu_instruction_subset_core cisc_checker u_checker (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .is_write(out_ch.is_write), .last(out_ch.last), .instr_done(out_ch.instr_done),
  .cycles_done(out_ch.cycles_done), .bus_address(out_ch.bus_address)
);

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the 8-bit CPU core with start and read-response beats, mostly as
// well-formed instruction streams, and checks every bus request and write
// beat against an in-bench model of the instruction subset. The start
// registers are set through the APB port between phases, extremes included.
// ----------------------------------------------------------------------------
import cisc_pkg::*;

class core_tracker;
  localparam logic [3:0] FLAG_Z = 4'h8;
  localparam logic [3:0] FLAG_N = 4'h4;
  localparam logic [3:0] FLAG_H = 4'h2;
  localparam logic [3:0] FLAG_C = 4'h1;

  logic [15:0] start_addr, start_sp, pc, sp;
  logic [7:0]  acc, op, lo;
  logic [3:0]  flags;
  logic [7:0]  gpr [6];
  phase_t      phase;
  beat_t       pending [$];
  int          errors, beats_checked, writes_checked;

  function new();
    start_addr = START_ADDR_RESET;
    start_sp = START_STACK_RESET;
    pc = start_addr;
    sp = start_sp;
    acc = 0;
    op = 0;
    lo = 0;
    flags = 0;
    foreach (gpr[i]) gpr[i] = 0;
    phase = PH_IDLE;
  endfunction

  function void set_reg(logic [0:0] idx, logic [15:0] v);
    if (idx == REG_START_ADDR) begin
      start_addr = v;
    end else begin
      start_sp = v;
      sp = v;
    end
  endfunction

  function void push(logic [15:0] a, logic [7:0] d, logic w, logic l, logic dn,
                     logic [4:0] cyc);
    beat_t b;
    b.bus_address = a;
    b.write_data = d;
    b.is_write = w;
    b.last = l;
    b.instr_done = dn;
    b.cycles_done = cyc;
    pending.push_back(b);
  endfunction

  function void fetch(logic [4:0] cyc);
    phase = PH_FETCH;
    push(pc, 8'h00, 1'b0, 1'b1, 1'b1, cyc);
  endfunction

  function void read_req(logic [15:0] a, phase_t ph);
    phase = ph;
    push(a, 8'h00, 1'b0, 1'b1, 1'b0, 5'd0);
  endfunction

  function void set_flags(logic z, logic n, logic h, logic c);
    flags = {z, n, h, c};
  endfunction

  function bit one_imm(logic [7:0] o);
    return o == OP_LD_B_N || o == OP_LD_C_N || o == OP_LD_D_N || o == OP_LD_E_N ||
           o == OP_LD_A_N || o == OP_JR_NZ;
  endfunction

  function bit two_imm(logic [7:0] o);
    return o == OP_LD_BC_NN || o == OP_LD_DE_NN || o == OP_LD_HL_NN ||
           o == OP_LD_SP_NN || o == OP_LD_NN_SP || o == OP_JP_NN;
  endfunction

  function void inc_reg(int i);
    logic [7:0] v;
    v = gpr[i];
    gpr[i] = v + 8'd1;
    set_flags(gpr[i] == 0, 1'b0, v[3:0] == 4'hF, (flags & FLAG_C) != 0);
  endfunction

  function void dec_reg(int i);
    logic [7:0] v;
    v = gpr[i];
    gpr[i] = v - 8'd1;
    set_flags(gpr[i] == 0, 1'b1, v[3:0] == 4'h0, (flags & FLAG_C) != 0);
  endfunction

  function void add_acc(logic [7:0] b);
    logic [8:0] s;
    logic [4:0] hs;
    s = {1'b0, acc} + {1'b0, b};
    hs = {1'b0, acc[3:0]} + {1'b0, b[3:0]};
    acc = s[7:0];
    set_flags(acc == 0, 1'b0, hs[4], s[8]);
  endfunction

  function void exec_short(logic [7:0] o);
    logic [4:0]  cyc;
    logic [7:0]  a;
    logic [15:0] hl;
    cyc = 5'd4;
    hl = {gpr[4], gpr[5]};
    case (o)
      OP_DEC_B: dec_reg(0);
      OP_INC_C: inc_reg(1);
      OP_DEC_C: dec_reg(1);
      OP_DEC_D: dec_reg(2);
      OP_INC_HL: begin
        {gpr[4], gpr[5]} = hl + 16'd1;
        cyc = 5'd8;
      end
      OP_LDD_HL_A: begin
        push(hl, acc, 1'b1, 1'b0, 1'b0, 5'd0);
        {gpr[4], gpr[5]} = hl - 16'd1;
        cyc = 5'd8;
      end
      OP_LD_HL_A: begin
        push(hl, acc, 1'b1, 1'b0, 1'b0, 5'd0);
        cyc = 5'd8;
      end
      OP_ADD_B: add_acc(gpr[0]);
      OP_ADD_C: add_acc(gpr[1]);
      OP_ADD_A: add_acc(acc);
      OP_SUB_B: begin
        a = acc;
        acc = a - gpr[0];
        set_flags(acc == 0, 1'b1, a[3:0] < gpr[0][3:0], a < gpr[0]);
      end
      OP_AND_B: begin
        acc = acc & gpr[0];
        set_flags(acc == 0, 1'b0, 1'b1, 1'b0);
      end
      OP_XOR_B: begin
        acc = acc ^ gpr[0];
        set_flags(acc == 0, 1'b0, 1'b0, 1'b0);
      end
      OP_OR_B: begin
        acc = acc | gpr[0];
        set_flags(acc == 0, 1'b0, 1'b0, 1'b0);
      end
      OP_XOR_A: begin
        acc = 0;
        set_flags(1'b1, 1'b0, 1'b0, 1'b0);
      end
      default: ;
    endcase
    fetch(cyc);
  endfunction

  function void note_response(logic kind, logic [7:0] d);
    logic [15:0] v;
    v = {d, lo};
    if (kind == 1'b0) begin
      pc = start_addr;
      fetch(5'd0);
      return;
    end
    case (phase)
      PH_FETCH: begin
        pc = pc + 16'd1;
        op = d;
        if (one_imm(d) || two_imm(d)) begin
          read_req(pc, PH_IMM1);
        end else if (d == OP_LD_A_DE) begin
          read_req({gpr[2], gpr[3]}, PH_DATA);
        end else begin
          exec_short(d);
        end
      end
      PH_IMM1: begin
        pc = pc + 16'd1;
        if (two_imm(op)) begin
          lo = d;
          read_req(pc, PH_IMM2);
        end else begin
          case (op)
            OP_LD_B_N: gpr[0] = d;
            OP_LD_C_N: gpr[1] = d;
            OP_LD_D_N: gpr[2] = d;
            OP_LD_E_N: gpr[3] = d;
            OP_LD_A_N: acc = d;
            default: ;
          endcase
          if (op == OP_JR_NZ && (flags & FLAG_Z) == 0) begin
            pc = pc + {{8{d[7]}}, d};
            fetch(5'd12);
          end else if (one_imm(op)) begin
            fetch(5'd8);
          end else begin
            fetch(5'd4);
          end
        end
      end
      PH_IMM2: begin
        pc = pc + 16'd1;
        case (op)
          OP_LD_BC_NN: begin gpr[0] = d; gpr[1] = lo; fetch(5'd12); end
          OP_LD_DE_NN: begin gpr[2] = d; gpr[3] = lo; fetch(5'd12); end
          OP_LD_HL_NN: begin {gpr[4], gpr[5]} = v; fetch(5'd12); end
          OP_LD_SP_NN: begin sp = v; fetch(5'd12); end
          OP_LD_NN_SP: begin
            push(v, sp[7:0], 1'b1, 1'b0, 1'b0, 5'd0);
            push(v + 16'd1, sp[15:8], 1'b1, 1'b0, 1'b0, 5'd0);
            fetch(5'd20);
          end
          OP_JP_NN: begin pc = v; fetch(5'd16); end
          default: fetch(5'd4);
        endcase
      end
      PH_DATA: begin
        acc = d;
        fetch(5'd8);
      end
      default: ;
    endcase
  endfunction

  function void check_request(beat_t got);
    beat_t want;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected beat %h", got);
      return;
    end
    want = pending.pop_front();
    beats_checked++;
    if (got.is_write) writes_checked++;
    if (got !== want) begin
      errors++;
      if (errors <= 10) begin
        $write("mismatch: expected addr %h data %h wr %b last %b done %b cyc %0d,",
               want.bus_address, want.write_data, want.is_write, want.last,
               want.instr_done, want.cycles_done);
        $display(" got addr %h data %h wr %b last %b done %b cyc %0d",
                 got.bus_address, got.write_data, got.is_write, got.last,
                 got.instr_done, got.cycles_done);
      end
    end
  endfunction
endclass

module tb_top;
  localparam int STALL_LIMIT = 2000;

  logic        clk, rst, psel, penable, pwrite;
  logic [2:2]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        steady;
  int          quiet_cycles, items_sent;
  core_tracker sb;
  beat_t       got;

  cisc_in_if  in_if ();
  cisc_out_if out_if ();

  cpu_instruction_subset_core dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_ch(in_if.sink), .out_ch(out_if.source)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_if.ready <= steady || ($urandom_range(0, 99) >= 10);
    if (!rst && out_if.valid && out_if.ready) begin
      got.bus_address = out_if.bus_address;
      got.write_data = out_if.write_data;
      got.is_write = out_if.is_write;
      got.last = out_if.last;
      got.instr_done = out_if.instr_done;
      got.cycles_done = out_if.cycles_done;
      sb.check_request(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[cpu_instruction_subset_core] ERROR");
        $finish;
      end
    end
  end

  task automatic send(logic kind, logic [7:0] d);
    if (!steady && $urandom_range(0, 99) < 10) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.kind <= kind;
    in_if.read_data <= d;
    do @(posedge clk); while (!in_if.ready);
    sb.note_response(kind, d);
    items_sent++;
  endtask

  task automatic apb_write(logic [0:0] idx, logic [15:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= idx;
    pwdata <= {16'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_opcode();
    logic [7:0] ops [30] = '{OP_LD_BC_NN, OP_DEC_B, OP_LD_B_N, OP_LD_NN_SP, OP_INC_C,
      OP_DEC_C, OP_LD_C_N, OP_LD_DE_NN, OP_DEC_D, OP_LD_D_N, OP_LD_A_DE, OP_LD_E_N,
      OP_JR_NZ, OP_LD_HL_NN, OP_INC_HL, OP_LD_SP_NN, OP_LDD_HL_A, OP_LD_A_N, OP_LD_HL_A,
      OP_ADD_B, OP_ADD_C, OP_ADD_A, OP_SUB_B, OP_AND_B, OP_XOR_B, OP_XOR_A, OP_OR_B,
      OP_JP_NN, 8'h76, 8'h00};
    if ($urandom_range(0, 99) < 8) return 8'($urandom);
    return ops[$urandom_range(0, 29)];
  endfunction

  task automatic random_items(int n);
    int r;
    logic [7:0] d;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (sb.phase == PH_IDLE) begin
        send(r < 85 ? 1'b0 : 1'b1, 8'($urandom));
      end else if (r < 3) begin
        send(1'b0, 8'($urandom));
      end else if (sb.phase == PH_FETCH && r < 93) begin
        send(1'b1, pick_opcode());
      end else begin
        case ($urandom_range(0, 5))
          0: d = 8'h00;
          1: d = 8'hFF;
          2: d = 8'h80;
          default: d = 8'($urandom);
        endcase
        send(1'b1, d);
      end
    end
  endtask

  initial begin
    logic [8:0] prog [$] = '{9'h155, 9'h000, 9'h13E, 9'h1FF, 9'h106, 9'h101, 9'h180,
      9'h105, 9'h105, 9'h10C, 9'h120, 9'h180, 9'h1AF, 9'h120, 9'h17F, 9'h121, 9'h100,
      9'h180, 9'h132, 9'h177, 9'h108, 9'h1FF, 9'h1FF, 9'h11A, 9'h1A5, 9'h1C3, 9'h134,
      9'h112, 9'h101, 9'h000};
    logic [15:0] addr_set [4] = '{16'h0000, 16'hFFFF, 16'h0000, 16'h0100};
    logic [15:0] sp_set [4] = '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFE};
    sb = new();
    steady = 1'b0;
    items_sent = 0;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_if.valid <= 1'b0;
    in_if.kind <= 1'b0;
    in_if.read_data <= 8'h00;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (prog[i]) send(prog[i][8], prog[i][7:0]);
    drain();
    for (int p = 0; p < 4; p++) begin
      if (p == 2) begin
        addr_set[p] = 16'($urandom);
        sp_set[p] = 16'($urandom);
      end
      apb_write(REG_START_ADDR, addr_set[p]);
      apb_write(REG_START_STACK, sp_set[p]);
      steady = (p == 1);
      send(1'b0, 8'h00);
      random_items(44);
      drain();
    end
    $display("Sent %0d response beats; checked %0d request beats, %0d of them writes.",
             items_sent, sb.beats_checked, sb.writes_checked);
    $display("Covered four start-register settings, directed flag and jump cases.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[cpu_instruction_subset_core] OK");
    end else begin
      $display("[cpu_instruction_subset_core] ERROR");
    end
    $finish;
  end
endmodule

// File: cpu_instruction_subset_core.f
rtl/core/cisc_pkg.sv
rtl/core/cisc_if.sv
rtl/core/cisc_exec.sv
rtl/core/cisc_outq.sv
rtl/core/cpu_instruction_subset_core.sv
rtl/core/cisc_checker.sv
dv/tb_top.sv
